/* rtl/gffra_pkg.sv */
// shared definitions for the grid first-fit rectangle allocator
// holds default geometry, result kinds and the control/status structs
// no dependencies
package gffra_pkg;

    localparam int GRID_COLS_DEF     = 8;
    localparam int GRID_ROWS_DEF     = 15;
    localparam int SLOT_CAPACITY_DEF = 120;

    // field widths fixed by the interface
    localparam int DIM_W   = 4;
    localparam int SLOT_W  = 7;
    localparam int COUNT_W = 7;
    // width wide enough for origin plus extent along either axis
    localparam int SUM_W   = 7;

    // kind of result to load into the output register
    typedef logic [1:0] res_kind_t;
    localparam res_kind_t RES_FAIL = 2'd0;
    localparam res_kind_t RES_SEQ  = 2'd1;
    localparam res_kind_t RES_GRID = 2'd2;

    typedef struct packed {
        logic      scan_start;
        logic      acc_step;
        logic      row_next;
        logic      mark_start;
        logic      mark_step;
        logic      res_load;
        res_kind_t res_kind;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic seq;
        logic bad_size;
        logic dy_last;
        logic fit_any;
        logic last_row;
        logic out_free;
    } status_t;

endpackage

/* rtl/gffra_ctrl.sv */
// control state machine for the grid allocator
// sequences check, row accumulate, fit evaluation, marking and result load
// depends on gffra_pkg
module gffra_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  gffra_pkg::status_t sts,
    output gffra_pkg::cmd_t    cmd
);
    import gffra_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_CHECK  = 3'd1;
    localparam logic [2:0] S_ACC    = 3'd2;
    localparam logic [2:0] S_EVAL   = 3'd3;
    localparam logic [2:0] S_MARK   = 3'd4;
    localparam logic [2:0] S_RESULT = 3'd5;

    logic [2:0] state_reg, state_next;
    res_kind_t  kind_reg, kind_next;

    assign s_ready = (state_reg == S_IDLE);

    always_comb begin
        state_next = state_reg;
        kind_next  = kind_reg;
        cmd        = '0;
        cmd.res_kind = kind_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK: begin
                if (sts.full) begin
                    kind_next  = RES_FAIL;
                    state_next = S_RESULT;
                end else if (sts.seq) begin
                    kind_next  = RES_SEQ;
                    state_next = S_RESULT;
                end else if (sts.bad_size) begin
                    kind_next  = RES_FAIL;
                    state_next = S_RESULT;
                end else begin
                    cmd.scan_start = 1'b1;
                    state_next     = S_ACC;
                end
            end
            S_ACC: begin
                cmd.acc_step = 1'b1;
                if (sts.dy_last) begin
                    state_next = S_EVAL;
                end
            end
            S_EVAL: begin
                if (sts.fit_any) begin
                    cmd.mark_start = 1'b1;
                    state_next     = S_MARK;
                end else if (sts.last_row) begin
                    kind_next  = RES_FAIL;
                    state_next = S_RESULT;
                end else begin
                    cmd.row_next = 1'b1;
                    state_next   = S_ACC;
                end
            end
            S_MARK: begin
                cmd.mark_step = 1'b1;
                if (sts.dy_last) begin
                    kind_next  = RES_GRID;
                    state_next = S_RESULT;
                end
            end
            S_RESULT: begin
                if (sts.out_free) begin
                    cmd.res_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            kind_reg  <= RES_FAIL;
        end else begin
            state_reg <= state_next;
            kind_reg  <= kind_next;
        end
    end

endmodule

/* rtl/gffra_dp.sv */
// datapath for the grid allocator: occupancy rows, scan counters,
// column fit search, item count, mode register and output register
// depends on gffra_pkg
module gffra_dp #(
    parameter int GRID_COLS     = gffra_pkg::GRID_COLS_DEF,
    parameter int GRID_ROWS     = gffra_pkg::GRID_ROWS_DEF,
    parameter int SLOT_CAPACITY = gffra_pkg::SLOT_CAPACITY_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    input  logic                          s_ready,
    input  logic [gffra_pkg::DIM_W-1:0]   s_rect_width,
    input  logic [gffra_pkg::DIM_W-1:0]   s_rect_height,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_placed,
    output logic [gffra_pkg::SLOT_W-1:0]  m_slot_index,
    output logic [gffra_pkg::COUNT_W-1:0] m_placed_count,
    input  logic                          cfg_wr_en,
    input  logic                          cfg_wr_data,
    input  gffra_pkg::cmd_t               cmd,
    output gffra_pkg::status_t            sts
);
    import gffra_pkg::*;

    localparam int COL_W  = $clog2(GRID_COLS);
    localparam int ROW_W  = $clog2(GRID_ROWS);
    localparam int BASE_W = $clog2(GRID_COLS * GRID_ROWS);
    localparam int CNT_W  = $clog2(SLOT_CAPACITY + 1);

    // occupancy, one register per grid row
    logic [GRID_COLS-1:0] rows_reg [GRID_ROWS];

    logic [DIM_W-1:0]     w_reg, h_reg;
    logic [ROW_W-1:0]     y_reg;
    logic [DIM_W-1:0]     dy_reg;
    logic [COL_W-1:0]     x_reg;
    logic [BASE_W-1:0]    base_reg;
    logic [GRID_COLS-1:0] acc_reg;
    logic [CNT_W-1:0]     count_reg;
    logic                 seq_mode_reg;

    logic                 m_valid_reg;
    logic                 m_placed_reg;
    logic [SLOT_W-1:0]    m_slot_reg;
    logic [COUNT_W-1:0]   m_count_reg;

    logic [SUM_W-1:0]     row_sum;
    logic [ROW_W-1:0]     row_idx;
    logic [GRID_COLS-1:0] row_data;
    logic [GRID_COLS-1:0] fit_vec;
    logic [COL_W-1:0]     fit_x;
    logic [GRID_COLS-1:0] mark_mask;
    logic [CNT_W-1:0]     count_inc;
    logic [31:0]          slot_wide;
    logic [31:0]          count_wide;
    logic [31:0]          seq_wide;

    assign row_sum  = SUM_W'(y_reg) + SUM_W'(dy_reg);
    assign row_idx  = row_sum[ROW_W-1:0];
    assign row_data = rows_reg[row_idx];

    // per origin column: window inside the grid and all covered bits free
    always_comb begin
        logic win_ok;
        fit_vec = '0;
        for (int x = 0; x < GRID_COLS; x++) begin
            win_ok = 1'b1;
            for (int i = 0; i < GRID_COLS; i++) begin
                if (acc_reg[i] && (i >= x) &&
                    (SUM_W'(i) < SUM_W'(x) + SUM_W'(w_reg))) begin
                    win_ok = 1'b0;
                end
            end
            fit_vec[x] = win_ok &&
                (SUM_W'(x) + SUM_W'(w_reg) <= SUM_W'(GRID_COLS));
        end
    end

    // lowest fitting column wins
    always_comb begin
        fit_x = '0;
        for (int x = GRID_COLS - 1; x >= 0; x--) begin
            if (fit_vec[x]) begin
                fit_x = COL_W'(x);
            end
        end
    end

    always_comb begin
        for (int i = 0; i < GRID_COLS; i++) begin
            mark_mask[i] = (SUM_W'(i) >= SUM_W'(x_reg)) &&
                (SUM_W'(i) < SUM_W'(x_reg) + SUM_W'(w_reg));
        end
    end

    assign count_inc  = count_reg + CNT_W'(1);
    assign slot_wide  = 32'(base_reg) + 32'(x_reg);
    assign count_wide = 32'(count_inc);
    assign seq_wide   = 32'(count_reg);

    assign sts.full     = (count_reg >= CNT_W'(SLOT_CAPACITY));
    assign sts.seq      = seq_mode_reg;
    assign sts.bad_size = (w_reg == '0) || (h_reg == '0) ||
                          (SUM_W'(w_reg) > SUM_W'(GRID_COLS)) ||
                          (SUM_W'(h_reg) > SUM_W'(GRID_ROWS));
    assign sts.dy_last  = (dy_reg == h_reg - DIM_W'(1));
    assign sts.fit_any  = |fit_vec;
    assign sts.last_row = (SUM_W'(y_reg) + SUM_W'(h_reg) == SUM_W'(GRID_ROWS));
    assign sts.out_free = !m_valid_reg || m_ready;

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int r = 0; r < GRID_ROWS; r++) begin
                rows_reg[r] <= '0;
            end
            count_reg    <= '0;
            seq_mode_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (cmd.mark_step) begin
                for (int r = 0; r < GRID_ROWS; r++) begin
                    if (row_idx == ROW_W'(r)) begin
                        rows_reg[r] <= rows_reg[r] | mark_mask;
                    end
                end
            end
            if (cfg_wr_en) begin
                seq_mode_reg <= cfg_wr_data;
            end
            if (cmd.res_load && (cmd.res_kind != RES_FAIL)) begin
                count_reg <= count_inc;
            end
            if (cmd.res_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // scan payload
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            w_reg <= s_rect_width;
            h_reg <= s_rect_height;
        end
        if (cmd.scan_start) begin
            y_reg    <= '0;
            dy_reg   <= '0;
            base_reg <= '0;
            acc_reg  <= '0;
        end else if (cmd.row_next) begin
            y_reg    <= y_reg + ROW_W'(1);
            dy_reg   <= '0;
            base_reg <= base_reg + BASE_W'(GRID_COLS);
            acc_reg  <= '0;
        end else if (cmd.acc_step) begin
            dy_reg  <= dy_reg + DIM_W'(1);
            acc_reg <= acc_reg | row_data;
        end else if (cmd.mark_start) begin
            dy_reg <= '0;
            x_reg  <= fit_x;
        end else if (cmd.mark_step) begin
            dy_reg <= dy_reg + DIM_W'(1);
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (cmd.res_load) begin
            case (cmd.res_kind)
                RES_GRID: begin
                    m_placed_reg <= 1'b1;
                    m_slot_reg   <= slot_wide[SLOT_W-1:0];
                    m_count_reg  <= count_wide[COUNT_W-1:0];
                end
                RES_SEQ: begin
                    m_placed_reg <= 1'b1;
                    m_slot_reg   <= seq_wide[SLOT_W-1:0];
                    m_count_reg  <= count_wide[COUNT_W-1:0];
                end
                default: begin
                    m_placed_reg <= 1'b0;
                    m_slot_reg   <= '0;
                    m_count_reg  <= seq_wide[COUNT_W-1:0];
                end
            endcase
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_placed       = m_placed_reg;
    assign m_slot_index   = m_slot_reg;
    assign m_placed_count = m_count_reg;

endmodule

/* rtl/grid_first_fit_rect_allocator.sv */
// first-fit rectangle allocator over a GRID_COLS x GRID_ROWS occupancy grid
// sequential mode and early failure go from the check straight to the result load; grid
//   mode first runs a row scan that ORs h occupancy rows per candidate origin row, one
//   row a cycle, then marks the h rows of the window found, h being the height
// throughput: one transaction at a time; next accepted once the result is loaded
// reset: synchronous active-low aresetn clears grid, item count and mode at once
module grid_first_fit_rect_allocator #(
    parameter int GRID_COLS     = gffra_pkg::GRID_COLS_DEF,
    parameter int GRID_ROWS     = gffra_pkg::GRID_ROWS_DEF,
    parameter int SLOT_CAPACITY = gffra_pkg::SLOT_CAPACITY_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [gffra_pkg::DIM_W-1:0]   s_rect_width,
    input  logic [gffra_pkg::DIM_W-1:0]   s_rect_height,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_placed,
    output logic [gffra_pkg::SLOT_W-1:0]  m_slot_index,
    output logic [gffra_pkg::COUNT_W-1:0] m_placed_count,
    input  logic                          cfg_wr_en,
    input  logic                          cfg_wr_data
);
    import gffra_pkg::*;

    cmd_t    cmd;
    status_t sts;

    gffra_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    gffra_dp #(
        .GRID_COLS     (GRID_COLS),
        .GRID_ROWS     (GRID_ROWS),
        .SLOT_CAPACITY (SLOT_CAPACITY)
    ) u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_rect_width   (s_rect_width),
        .s_rect_height  (s_rect_height),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_placed       (m_placed),
        .m_slot_index   (m_slot_index),
        .m_placed_count (m_placed_count),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .cmd            (cmd),
        .sts            (sts)
    );

endmodule

/* tb/gffra_alloc_monitor.sv */
// transaction monitor for grid_first_fit_rect_allocator: predicts each placement and compares
// keeps its own occupancy grid, item count and mode; reports mismatches to the test top
// depends on gffra_pkg for field widths and default geometry
module gffra_alloc_monitor (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    input  logic                          s_ready,
    input  logic [gffra_pkg::DIM_W-1:0]   s_rect_width,
    input  logic [gffra_pkg::DIM_W-1:0]   s_rect_height,
    input  logic                          m_valid,
    input  logic                          m_ready,
    input  logic                          m_placed,
    input  logic [gffra_pkg::SLOT_W-1:0]  m_slot_index,
    input  logic [gffra_pkg::COUNT_W-1:0] m_placed_count,
    input  logic                          cfg_wr_en,
    input  logic                          cfg_wr_data,
    output int                            mismatches,
    output int                            outstanding,
    output int                            results_seen,
    output int                            placements
);
    import gffra_pkg::*;

    localparam int COLS = GRID_COLS_DEF;
    localparam int ROWS = GRID_ROWS_DEF;
    localparam int CAP  = SLOT_CAPACITY_DEF;

    typedef struct packed {
        logic               placed;
        logic [SLOT_W-1:0]  slot;
        logic [COUNT_W-1:0] count;
    } alloc_result_t;

    logic [COLS*ROWS-1:0] cell_used;
    int unsigned          items_placed;
    logic                 seq_slots;
    alloc_result_t        pending_allocs[$];

    function automatic logic area_free(input int x, input int y, input int w, input int h);
        if (x + w > COLS || y + h > ROWS)
            return 1'b0;
        for (int dy = 0; dy < h; dy++)
            for (int dx = 0; dx < w; dx++)
                if (cell_used[(y + dy) * COLS + x + dx])
                    return 1'b0;
        return 1'b1;
    endfunction

    // first-fit scan, row-major; updates the grid and count on success
    function automatic alloc_result_t allocate(input logic [DIM_W-1:0] w,
                                               input logic [DIM_W-1:0] h);
        alloc_result_t r;
        r = '0;
        if (items_placed < CAP) begin
            if (seq_slots) begin
                r.placed = 1'b1;
                r.slot   = SLOT_W'(items_placed);
            end else if (w != 0 && h != 0) begin
                for (int y = 0; y < ROWS && !r.placed; y++)
                    for (int x = 0; x < COLS && !r.placed; x++)
                        if (!cell_used[y * COLS + x] && area_free(x, y, w, h)) begin
                            for (int dy = 0; dy < h; dy++)
                                for (int dx = 0; dx < w; dx++)
                                    cell_used[(y + dy) * COLS + x + dx] = 1'b1;
                            r.placed = 1'b1;
                            r.slot   = SLOT_W'(x + y * COLS);
                        end
            end
            if (r.placed)
                items_placed++;
        end
        r.count = COUNT_W'(items_placed);
        return r;
    endfunction

    initial begin
        mismatches   = 0;
        outstanding  = 0;
        results_seen = 0;
        placements   = 0;
    end

    always @(posedge aclk) begin
        alloc_result_t want;
        if (!aresetn) begin
            cell_used    = '0;
            items_placed = 0;
            seq_slots    = 1'b0;
            pending_allocs.delete();
        end else begin
            if (cfg_wr_en)
                seq_slots = cfg_wr_data;
            if (s_valid && s_ready)
                pending_allocs.push_back(allocate(s_rect_width, s_rect_height));
            if (m_valid && m_ready) begin
                if (pending_allocs.size() == 0) begin
                    $error("result transaction with no request waiting");
                    mismatches++;
                end else begin
                    want = pending_allocs.pop_front();
                    if (m_placed !== want.placed) begin
                        $error("placed: expected %0d, actual %0d", want.placed, m_placed);
                        mismatches++;
                    end
                    if (m_slot_index !== want.slot) begin
                        $error("slot_index: expected %0d, actual %0d", want.slot, m_slot_index);
                        mismatches++;
                    end
                    if (m_placed_count !== want.count) begin
                        $error("placed_count: expected %0d, actual %0d",
                               want.count, m_placed_count);
                        mismatches++;
                    end
                    results_seen++;
                    if (want.placed)
                        placements++;
                end
            end
        end
        outstanding = pending_allocs.size();
    end

endmodule

/* tb/grid_first_fit_rect_allocator_test.sv */
// top of the grid_first_fit_rect_allocator test: clock, reset, requests, mode writes, verdict
// depends on gffra_pkg, the block itself and gffra_alloc_monitor
module grid_first_fit_rect_allocator_test;
    import gffra_pkg::*;

    localparam logic MODE_GRID    = 1'b0;
    localparam logic MODE_SEQ     = 1'b1;
    localparam int   QUIET_LIMIT  = 2000;
    localparam int   LONG_HOLD    = 300;
    localparam int   SETTLE       = 4;
    localparam int   DRAIN_CYCLES = 100;

    logic               aclk = 1'b0;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    logic [DIM_W-1:0]   s_rect_width;
    logic [DIM_W-1:0]   s_rect_height;
    logic               m_valid;
    logic               m_ready;
    logic               m_placed;
    logic [SLOT_W-1:0]  m_slot_index;
    logic [COUNT_W-1:0] m_placed_count;
    logic               cfg_wr_en;
    logic               cfg_wr_data;

    int   mismatches;
    int   outstanding;
    int   results_seen;
    int   placements;
    int   send_idle_pct  = 0;
    int   recv_stall_pct = 0;
    int   pace_phase     = 0;
    int   quiet_cycles   = 0;
    logic long_hold_req  = 1'b0;

    always #2 aclk = ~aclk;

    grid_first_fit_rect_allocator uut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_rect_width   (s_rect_width),
        .s_rect_height  (s_rect_height),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_placed       (m_placed),
        .m_slot_index   (m_slot_index),
        .m_placed_count (m_placed_count),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data)
    );

    gffra_alloc_monitor monitor (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_rect_width   (s_rect_width),
        .s_rect_height  (s_rect_height),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_placed       (m_placed),
        .m_slot_index   (m_slot_index),
        .m_placed_count (m_placed_count),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .mismatches     (mismatches),
        .outstanding    (outstanding),
        .results_seen   (results_seen),
        .placements     (placements)
    );

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic send_rect(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid       <= 1'b1;
        s_rect_width  <= w;
        s_rect_height <= h;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    task automatic send_random();
        logic [DIM_W-1:0] w;
        logic [DIM_W-1:0] h;
        int               pick;
        pick = $urandom_range(99);
        if (pick < 70) begin
            // small rectangles pack the grid gradually
            w = DIM_W'($urandom_range(4, 1));
            h = DIM_W'($urandom_range(3, 1));
        end else if (pick < 85) begin
            w = DIM_W'($urandom_range(8, 1));
            h = DIM_W'($urandom_range(15, 1));
        end else begin
            // zero and oversize dimensions
            w = DIM_W'($urandom_range(15, 0));
            h = DIM_W'($urandom_range(15, 0));
        end
        send_rect(w, h);
    endtask

    task automatic write_mode(input logic mode);
        s_valid <= 1'b0;
        while (outstanding != 0)
            @(negedge aclk);
        repeat (SETTLE) @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= mode;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    task automatic next_pace();
        case (pace_phase % 4)
            0: begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
            1: begin
                send_idle_pct  = 49;
                recv_stall_pct = 0;
            end
            2: begin
                send_idle_pct  = 0;
                recv_stall_pct = 49;
            end
            default: begin
                send_idle_pct  = 27;
                recv_stall_pct = 27;
            end
        endcase
        pace_phase++;
    endtask

    task automatic random_run(input int n);
        for (int i = 0; i < n; i++) begin
            if (i % 50 == 0)
                next_pace();
            send_random();
        end
    endtask

    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (long_hold_req) begin
                // long back-pressure: the block holds its result and stops taking requests
                m_ready <= 1'b0;
                repeat (LONG_HOLD) @(negedge aclk);
                long_hold_req = 1'b0;
            end
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles", QUIET_LIMIT);
            $display("grid_first_fit_rect_allocator test failed");
            $finish;
        end
    end

    initial begin
        aresetn       = 1'b0;
        s_valid       = 1'b0;
        s_rect_width  = '0;
        s_rect_height = '0;
        cfg_wr_en     = 1'b0;
        cfg_wr_data   = 1'b0;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed grid requests: zero sizes, oversize, full-height and full-width fits
        write_mode(MODE_GRID);
        send_rect(4'd0, 4'd0);
        send_rect(4'd0, 4'd5);
        send_rect(4'd5, 4'd0);
        send_rect(4'd9, 4'd1);
        send_rect(4'd15, 4'd15);
        send_rect(4'd1, 4'd15);
        send_rect(4'd8, 4'd15);
        send_rect(4'd8, 4'd1);
        send_rect(4'd7, 4'd1);
        send_rect(4'd7, 4'd2);
        send_rect(4'd1, 4'd15);
        send_rect(4'd2, 4'd2);
        send_rect(4'd1, 4'd1);
        send_rect(4'd3, 4'd4);
        send_rect(4'd8, 4'd2);

        // sequential slots ignore dimensions, zero included
        write_mode(MODE_SEQ);
        send_rect(4'd0, 4'd0);
        send_rect(4'd15, 4'd15);
        send_rect(4'd8, 4'd15);

        // back to grid mode: grid kept across the mode change
        write_mode(MODE_GRID);
        for (int i = 0; i < 300; i++) begin
            if (i % 50 == 0)
                next_pace();
            if (i == 60)
                long_hold_req = 1'b1;
            send_random();
        end

        // sequential mode runs the count up to capacity and then rejects
        write_mode(MODE_SEQ);
        random_run(180);

        // full count rejects in grid mode as well
        write_mode(MODE_GRID);
        random_run(100);

        write_mode(MODE_SEQ);
        random_run(100);

        s_valid <= 1'b0;
        while (outstanding != 0)
            @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);

        $display("covered %0d requests with %0d placements: first-fit grid fill, zero and",
                 results_seen, placements);
        $display("oversize rejects, sequential slots to capacity, full rejects in both modes");
        if (mismatches == 0 && outstanding == 0)
            $display("grid_first_fit_rect_allocator test passed");
        else
            $display("grid_first_fit_rect_allocator test failed");
        $finish;
    end

endmodule
